### rtl/sct_pkg.sv
// Shared types and constants of the shell command tokenizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sct_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Byte values the lexer cares about.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef enum logic [4:0] {
    CC_OTHER  = 5'd0,
    CC_BLANK  = 5'd1,
    CC_NL     = 5'd2,
    CC_HASH   = 5'd3,
    CC_TWO    = 5'd4,
    CC_GT     = 5'd5,
    CC_AMP    = 5'd6,
    CC_PIPE   = 5'd7,
    CC_LT     = 5'd8,
    CC_SEMI   = 5'd9,
    CC_LPAREN = 5'd10,
    CC_RPAREN = 5'd11,
    CC_SQUOTE = 5'd12,
    CC_DQUOTE = 5'd13,
    CC_BSLASH = 5'd14,
    CC_DOLLAR = 5'd15,
    CC_BTICK  = 5'd16
  } char_class_t;

  typedef enum logic [2:0] {
    EV_BYTE = 3'd0,
    EV_SEG  = 3'd1,
    EV_WORD = 3'd2,
    EV_OP   = 3'd3,
    EV_ERR  = 3'd4,
    EV_DONE = 3'd5
  } ev_kind_t;

  typedef enum logic [3:0] {
    OP_IN      = 4'd0,
    OP_OUT     = 4'd1,
    OP_APPEND  = 4'd2,
    OP_ERR     = 4'd3,
    OP_PIPE    = 4'd4,
    OP_OR      = 4'd5,
    OP_AMP     = 4'd6,
    OP_AND     = 4'd7,
    OP_SEMI    = 4'd8,
    OP_LPAREN  = 4'd9,
    OP_RPAREN  = 4'd10,
    OP_NEWLINE = 4'd11
  } op_code_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] text_byte;
    logic       seg_expand;
    logic [3:0] op_code;
    logic       last_result;
  } out_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic [7:0]  char_byte;
    logic        end_of_line;
    char_class_t cls;
  } item_t;

endpackage

`default_nettype wire

### rtl/sct_front.sv
// Front end of the tokenizer: accepts input bytes and tags each with its class.
// Depends on sct_pkg; feeds sct_queue.
`default_nettype none

module sct_front (
  input  wire               in_valid,
  output logic              in_ready,
  input  sct_pkg::in_t      in_data,
  output logic              wr_valid,
  input  wire               wr_ready,
  output sct_pkg::item_t    wr_item
);
  import sct_pkg::*;

  char_class_t cls;

  always_comb begin
    unique case (in_data.char_byte)
      CH_SPACE, CH_TAB: cls = CC_BLANK;
      CH_NL:            cls = CC_NL;
      CH_HASH:          cls = CC_HASH;
      CH_TWO:           cls = CC_TWO;
      CH_GT:            cls = CC_GT;
      CH_AMP:           cls = CC_AMP;
      CH_PIPE:          cls = CC_PIPE;
      CH_LT:            cls = CC_LT;
      CH_SEMI:          cls = CC_SEMI;
      CH_LPAREN:        cls = CC_LPAREN;
      CH_RPAREN:        cls = CC_RPAREN;
      CH_SQUOTE:        cls = CC_SQUOTE;
      CH_DQUOTE:        cls = CC_DQUOTE;
      CH_BSLASH:        cls = CC_BSLASH;
      CH_DOLLAR:        cls = CC_DOLLAR;
      CH_BTICK:         cls = CC_BTICK;
      default:          cls = CC_OTHER;
    endcase
  end

  assign wr_valid            = in_valid;
  assign in_ready            = wr_ready;
  assign wr_item.char_byte   = in_data.char_byte;
  assign wr_item.end_of_line = in_data.end_of_line;
  assign wr_item.cls         = cls;

endmodule

`default_nettype wire

### rtl/sct_queue.sv
// Short FIFO of classified items between the tokenizer front and back ends.
// Depends on sct_pkg for the item type.
`default_nettype none

module sct_queue #(
  parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  sct_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  wire             rd_ready,
  output sct_pkg::item_t  rd_item
);
  import sct_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### rtl/sct_back.sv
// Back end of the tokenizer: runs the lexer state machine on queued items and
// drains up to four events per item through a shifting output buffer. Uses sct_pkg.
`default_nettype none

module sct_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  output logic            q_ready,
  input  sct_pkg::item_t  q_item,
  output logic            out_valid,
  input  wire             out_ready,
  output sct_pkg::out_t   out_data
);
  import sct_pkg::*;

  localparam int NRES = 4;

  typedef enum logic [7:0] {
    M_NORMAL  = 8'b0000_0001,
    M_SINGLE  = 8'b0000_0010,
    M_DOUBLE  = 8'b0000_0100,
    M_DQESC   = 8'b0000_1000,
    M_ESC     = 8'b0001_0000,
    M_TWO     = 8'b0010_0000,
    M_COMMENT = 8'b0100_0000,
    M_OP      = 8'b1000_0000
  } lex_mode_t;

  typedef enum logic [1:0] {
    H_NONE = 2'd0,
    H_GT   = 2'd1,
    H_AMP  = 2'd2,
    H_PIPE = 2'd3
  } held_t;

  function automatic out_t mk_res(ev_kind_t kind, logic [7:0] b, logic expand,
                                  op_code_t op);
    out_t r;
    r.event_kind  = kind;
    r.text_byte   = b;
    r.seg_expand  = expand;
    r.op_code     = op;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic op_code_t single_op(char_class_t cls);
    op_code_t op;
    unique case (cls)
      CC_LT:     op = OP_IN;
      CC_PIPE:   op = OP_PIPE;
      CC_AMP:    op = OP_AMP;
      CC_SEMI:   op = OP_SEMI;
      CC_LPAREN: op = OP_LPAREN;
      CC_RPAREN: op = OP_RPAREN;
      default:   op = OP_OUT;
    endcase
    return op;
  endfunction

  // A held code of none behaves as a pipe, which never occurs in practice.
  function automatic op_code_t held_single(held_t h);
    op_code_t op;
    unique case (h)
      H_GT:    op = OP_OUT;
      H_AMP:   op = OP_AMP;
      default: op = OP_PIPE;
    endcase
    return op;
  endfunction

  function automatic op_code_t held_double(held_t h);
    op_code_t op;
    unique case (h)
      H_GT:    op = OP_APPEND;
      H_AMP:   op = OP_AND;
      default: op = OP_OR;
    endcase
    return op;
  endfunction

  function automatic logic held_match(held_t h, char_class_t cls);
    logic m;
    unique case (h)
      H_GT:    m = (cls == CC_GT);
      H_AMP:   m = (cls == CC_AMP);
      default: m = (cls == CC_PIPE);
    endcase
    return m;
  endfunction

  lex_mode_t  mode_r, mode_nxt;
  held_t      held_r, held_nxt;
  logic       wsf_r, wsf_nxt;
  logic       bto_r, bto_nxt;
  logic       wo_r, wo_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  out_t       res_r [NRES];
  out_t       res_v [NRES];
  logic [2:0] n_v;
  logic [1:0] lidx;
  logic       run_norm, run_dbl, fin, post_done;
  logic [7:0] c;
  char_class_t cls;
  logic       pop, xfer;

  assign q_ready   = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign pop       = q_valid && q_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = res_r[0];
  assign xfer      = out_valid && out_ready;

  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    wsf_nxt   = wsf_r;
    bto_nxt   = bto_r;
    wo_nxt    = wo_r;
    n_v       = 3'd0;
    lidx      = 2'd0;
    run_norm  = 1'b0;
    run_dbl   = 1'b0;
    fin       = 1'b0;
    post_done = 1'b0;
    c         = q_item.char_byte;
    cls       = q_item.cls;
    for (int i = 0; i < NRES; i++) begin
      res_v[i] = '0;
    end

    if (q_item.end_of_line) begin
      if (mode_r == M_SINGLE || mode_r == M_DOUBLE || mode_r == M_DQESC) begin
        // Unterminated quote: report it and drop straight back to reset state.
        res_v[n_v[1:0]] = mk_res(EV_ERR, 8'h00, 1'b0, OP_IN);
        n_v      = n_v + 3'd1;
        mode_nxt = M_NORMAL;
        held_nxt = H_NONE;
        wsf_nxt  = 1'b1;
        bto_nxt  = 1'b0;
        wo_nxt   = 1'b0;
      end else begin
        unique case (mode_r)
          M_ESC: begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, CH_BSLASH, 1'b0, OP_IN);
            n_v     = n_v + 3'd1;
            bto_nxt = 1'b1;
            wo_nxt  = 1'b1;
          end
          M_TWO: begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, CH_TWO, 1'b0, OP_IN);
            n_v     = n_v + 3'd1;
            bto_nxt = 1'b1;
            wo_nxt  = 1'b1;
          end
          M_OP: begin
            res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, held_single(held_r));
            n_v = n_v + 3'd1;
          end
          default: begin
          end
        endcase
        fin       = 1'b1;
        post_done = 1'b1;
      end
    end else begin
      unique case (mode_r)
        M_SINGLE: begin
          if (cls == CC_SQUOTE) begin
            res_v[n_v[1:0]] = mk_res(EV_SEG, 8'h00, 1'b0, OP_IN);
            mode_nxt = M_NORMAL;
          end else begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, c, 1'b0, OP_IN);
          end
          n_v = n_v + 3'd1;
        end
        M_DOUBLE: begin
          run_dbl = 1'b1;
        end
        M_DQESC: begin
          mode_nxt = M_DOUBLE;
          if (cls == CC_DOLLAR || cls == CC_DQUOTE || cls == CC_BSLASH ||
              cls == CC_BTICK) begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, c, 1'b0, OP_IN);
            n_v = n_v + 3'd1;
          end else begin
            // Backslash before an ordinary byte stays in the text.
            res_v[n_v[1:0]] = mk_res(EV_BYTE, CH_BSLASH, 1'b0, OP_IN);
            n_v     = n_v + 3'd1;
            run_dbl = 1'b1;
          end
        end
        M_ESC: begin
          mode_nxt = M_NORMAL;
          bto_nxt  = 1'b1;
          wo_nxt   = 1'b1;
          if (cls == CC_NL) begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, CH_BSLASH, 1'b0, OP_IN);
            run_norm = 1'b1;
          end else begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, c, 1'b0, OP_IN);
          end
          n_v = n_v + 3'd1;
        end
        M_TWO: begin
          mode_nxt = M_NORMAL;
          if (cls == CC_GT) begin
            res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, OP_ERR);
          end else begin
            res_v[n_v[1:0]] = mk_res(EV_BYTE, CH_TWO, 1'b0, OP_IN);
            bto_nxt  = 1'b1;
            wo_nxt   = 1'b1;
            wsf_nxt  = 1'b0;
            run_norm = 1'b1;
          end
          n_v = n_v + 3'd1;
        end
        M_COMMENT: begin
          if (cls == CC_NL) begin
            mode_nxt = M_NORMAL;
            run_norm = 1'b1;
          end
        end
        M_OP: begin
          held_nxt = H_NONE;
          mode_nxt = M_NORMAL;
          wsf_nxt  = 1'b1;
          if (held_match(held_r, cls)) begin
            res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, held_double(held_r));
          end else begin
            res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, held_single(held_r));
            run_norm = 1'b1;
          end
          n_v = n_v + 3'd1;
        end
        default: begin
          run_norm = 1'b1;
        end
      endcase
    end

    if (run_dbl) begin
      if (cls == CC_DQUOTE) begin
        res_v[n_v[1:0]] = mk_res(EV_SEG, 8'h00, 1'b1, OP_IN);
        n_v      = n_v + 3'd1;
        mode_nxt = M_NORMAL;
      end else if (cls == CC_BSLASH) begin
        mode_nxt = M_DQESC;
      end else begin
        res_v[n_v[1:0]] = mk_res(EV_BYTE, c, 1'b0, OP_IN);
        n_v = n_v + 3'd1;
      end
    end

    if (run_norm) begin
      fin = (cls == CC_BLANK) || (cls == CC_NL) || (cls == CC_GT) ||
            (cls == CC_AMP) || (cls == CC_PIPE) || (cls == CC_LT) ||
            (cls == CC_SEMI) || (cls == CC_LPAREN) || (cls == CC_RPAREN);
    end

    // Close the pending word: bare segment end first, then the word end.
    if (fin && wo_nxt) begin
      if (bto_nxt) begin
        res_v[n_v[1:0]] = mk_res(EV_SEG, 8'h00, 1'b1, OP_IN);
        n_v     = n_v + 3'd1;
        bto_nxt = 1'b0;
      end
      res_v[n_v[1:0]] = mk_res(EV_WORD, 8'h00, 1'b0, OP_IN);
      n_v    = n_v + 3'd1;
      wo_nxt = 1'b0;
    end

    if (run_norm) begin
      priority if (cls == CC_BLANK) begin
        wsf_nxt = 1'b1;
      end else if (cls == CC_NL) begin
        res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, OP_NEWLINE);
        n_v     = n_v + 3'd1;
        wsf_nxt = 1'b1;
      end else if (wsf_nxt && cls == CC_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (wsf_nxt && cls == CC_TWO) begin
        mode_nxt = M_TWO;
      end else if (cls == CC_GT || cls == CC_AMP || cls == CC_PIPE) begin
        held_nxt = (cls == CC_GT) ? H_GT : ((cls == CC_AMP) ? H_AMP : H_PIPE);
        mode_nxt = M_OP;
      end else if (cls == CC_LT || cls == CC_SEMI || cls == CC_LPAREN ||
                   cls == CC_RPAREN) begin
        res_v[n_v[1:0]] = mk_res(EV_OP, 8'h00, 1'b0, single_op(cls));
        n_v     = n_v + 3'd1;
        wsf_nxt = 1'b1;
      end else if (cls == CC_SQUOTE || cls == CC_DQUOTE) begin
        if (bto_nxt) begin
          res_v[n_v[1:0]] = mk_res(EV_SEG, 8'h00, 1'b1, OP_IN);
          n_v     = n_v + 3'd1;
          bto_nxt = 1'b0;
        end
        wo_nxt   = 1'b1;
        mode_nxt = (cls == CC_SQUOTE) ? M_SINGLE : M_DOUBLE;
        wsf_nxt  = 1'b0;
      end else if (cls == CC_BSLASH) begin
        mode_nxt = M_ESC;
        wsf_nxt  = 1'b0;
      end else begin
        res_v[n_v[1:0]] = mk_res(EV_BYTE, c, 1'b0, OP_IN);
        n_v     = n_v + 3'd1;
        bto_nxt = 1'b1;
        wo_nxt  = 1'b1;
        wsf_nxt = 1'b0;
      end
    end

    if (post_done) begin
      res_v[n_v[1:0]] = mk_res(EV_DONE, 8'h00, 1'b0, OP_IN);
      n_v      = n_v + 3'd1;
      mode_nxt = M_NORMAL;
      held_nxt = H_NONE;
      wsf_nxt  = 1'b1;
      bto_nxt  = 1'b0;
      wo_nxt   = 1'b0;
    end

    if (n_v != 3'd0) begin
      lidx = 2'(n_v - 3'd1);
      res_v[lidx].last_result = 1'b1;
    end
  end

  always_comb begin
    if (pop) begin
      cnt_nxt = n_v;
    end else if (xfer) begin
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      held_r <= H_NONE;
      wsf_r  <= 1'b1;
      bto_r  <= 1'b0;
      wo_r   <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        mode_r <= mode_nxt;
        held_r <= held_nxt;
        wsf_r  <= wsf_nxt;
        bto_r  <= bto_nxt;
        wo_r   <= wo_nxt;
      end
    end
  end

  // The head of the buffer is the event on offer; a transfer shifts the rest up.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NRES; i++) begin
        res_r[i] <= res_v[i];
      end
    end else if (xfer) begin
      for (int i = 0; i < NRES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/shell_command_tokenizer_unit.sv
// Path: the first event of a byte is registered in the queue and then in the
// output buffer before it is offered.
// Throughput: one byte per cycle while each byte yields at most one event and the
// output is not stalled; a multi-event byte holds the buffer, one event per cycle.
// The front queue of QUEUE_DEPTH entries absorbs input while the buffer drains.
// Reset: synchronous, active low; clears the queue and lexer state, no clear pass.
`default_nettype none

module shell_command_tokenizer_unit #(
  parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  sct_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output sct_pkg::out_t  out_data
);
  import sct_pkg::*;

  logic  wr_valid, wr_ready;
  item_t wr_item;
  logic  q_valid, q_ready;
  item_t q_item;

  sct_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item)
  );

  sct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  sct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Events of one byte go out back to back; only the final one may leave a gap.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_result |=> out_valid)
    else $error("event burst broken before its final event");

  a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_ERR || out_data.event_kind == EV_DONE)
      |-> out_data.last_result)
    else $error("error or line-done event not marked as final");

  a_text_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != EV_BYTE |-> out_data.text_byte == 8'h00)
    else $error("text byte set on a non-byte event");
`endif

endmodule

`default_nettype wire
